// ===== hdl/ljfa_pkg.sv =====
// Shared types and constants of the Lennard-Jones force accumulator.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none
package ljfa_pkg;

  // Queue between front end and back end
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic CFG_CUTOFF_SQ = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  localparam logic [27:0] CUTOFF_SQ_RST = 28'd9437184;
  localparam logic [31:0] TIME_STEP_RST = 32'd4294967;

  // One classified item as the back end sees it
  typedef struct packed {
    logic               proc;   // real pair inside the coarse box
    logic               emit;   // item closes the particle
    logic signed [26:0] dx;
    logic signed [26:0] dy;
    logic signed [26:0] dz;
    logic signed [47:0] mom_x;
    logic signed [47:0] mom_y;
    logic signed [47:0] mom_z;
  } ljfa_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ljfa_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_PREP,
    ST_EMIT
  } ljfa_state_t;

  // Multiply steps of the back end, in order of execution
  typedef enum logic [3:0] {
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_S2,
    OP_S4,
    OP_S3,
    OP_C,
    OP_DF,
    OP_TX,
    OP_TY,
    OP_TZ
  } ljfa_op_t;

endpackage
`default_nettype wire

// ===== hdl/ljfa_front.sv =====
// Front end: forms the position differences and classifies each item.
// Depends on ljfa_pkg; feeds ljfa_queue.
`default_nettype none
module ljfa_front (
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  signed [31:0]   in_key_x,
  input  wire  signed [31:0]   in_key_y,
  input  wire  signed [31:0]   in_key_z,
  input  wire  signed [31:0]   in_nbr_x,
  input  wire  signed [31:0]   in_nbr_y,
  input  wire  signed [31:0]   in_nbr_z,
  input  wire  signed [47:0]   in_mom_in_x,
  input  wire  signed [47:0]   in_mom_in_y,
  input  wire  signed [47:0]   in_mom_in_z,
  input  wire                  in_has_partner,
  input  wire                  in_last_partner,
  input  ljfa_pkg::ljfa_qstat_t qstat,
  output logic                 push,
  output ljfa_pkg::ljfa_item_t push_item
);
  import ljfa_pkg::*;

  logic signed [32:0] dx, dy, dz;
  logic               in_box;

  // Differences, one bit wider than the positions
  assign dx = 33'(in_nbr_x) - 33'(in_key_x);
  assign dy = 33'(in_nbr_y) - 33'(in_key_y);
  assign dz = 33'(in_nbr_z) - 33'(in_key_z);

  // Every component within +-2^25, else the pair is out of cutoff
  assign in_box = (dx >= -33'sd33554432) && (dx <= 33'sd33554432) &&
                  (dy >= -33'sd33554432) && (dy <= 33'sd33554432) &&
                  (dz >= -33'sd33554432) && (dz <= 33'sd33554432);

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  // Build the queue entry
  always_comb begin
    push_item.proc  = in_has_partner && in_box;
    push_item.emit  = !in_has_partner || in_last_partner;
    push_item.dx    = dx[26:0];
    push_item.dy    = dy[26:0];
    push_item.dz    = dz[26:0];
    push_item.mom_x = in_mom_in_x;
    push_item.mom_y = in_mom_in_y;
    push_item.mom_z = in_mom_in_z;
  end
endmodule
`default_nettype wire

// ===== hdl/ljfa_queue.sv =====
// Short item queue between the front end and the back end.
// Depends on ljfa_pkg for the entry type and depth.
`default_nettype none
module ljfa_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  ljfa_pkg::ljfa_item_t  push_item,
  input  wire                   pop,
  output ljfa_pkg::ljfa_item_t  head,
  output ljfa_pkg::ljfa_qstat_t qstat
);
  import ljfa_pkg::*;

  ljfa_item_t       entry_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign qstat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ljfa_back.sv =====
// Back end: sequencer with a bit-serial reciprocal and a shared 32x32
// multiplier; accumulates the force and drives the result register.
// Depends on ljfa_pkg; takes items from ljfa_queue.
`default_nettype none
module ljfa_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [27:0]           cutoff_sq,
  input  wire  [31:0]           time_step,
  input  ljfa_pkg::ljfa_item_t  head,
  input  ljfa_pkg::ljfa_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic signed [47:0]    out_mom_out_x,
  output logic signed [47:0]    out_mom_out_y,
  output logic signed [47:0]    out_mom_out_z,
  output logic                  out_saturated
);
  import ljfa_pkg::*;

  localparam logic [63:0] U63    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S48LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] A_LIM  = U63 / 24;
  localparam logic [63:0] T_LIM  = U63 / 2;
  localparam logic [63:0] ONE32  = 64'h0000_0001_0000_0000;
  localparam logic [6:0]  DIV_LAST = 7'd72;
  localparam logic [6:0]  MUL_LAST = 7'd5;

  ljfa_state_t state_r, state_nxt;
  ljfa_op_t    op_r;
  ljfa_item_t  item_r;
  logic [6:0]  cnt_r;
  logic [51:0] r_r;
  logic [51:0] rem_r;
  logic [63:0] q_r;
  logic [63:0] s_r, s2_r, s3_r, s4_r;
  logic [63:0] a_r, b_mag_r, c_mag_r, df_mag_r;
  logic        b_neg_r, c_neg_r, df_neg_r;
  logic [127:0] acc_r;
  logic [63:0] pp_r;
  logic [1:0]  pp_w_r;
  logic signed [47:0] sum_x_r, sum_y_r, sum_z_r;
  logic        clip_r;
  logic        out_valid_r;
  logic signed [47:0] out_x_r, out_y_r, out_z_r;
  logic        out_sat_r;

  logic        out_load;
  logic [25:0] dxm, dym, dzm;
  logic [63:0] op_a, op_b, op_lim;
  logic [6:0]  op_sh;
  logic        op_neg;
  logic [31:0] a_part, b_part;
  logic [63:0] prod;
  logic [127:0] qwide;
  logic        mul_sat;
  logic [63:0] mul_res;
  logic signed [48:0] term;
  logic [52:0] rem_sh;
  logic        div_ge;
  logic        a_sat, t_sat;
  logic [63:0] t_val;
  logic signed [48:0] mx, my, mz;
  logic        ox_sat, oy_sat, oz_sat;

  // Saturate a 49-bit signed sum to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] res;
    if (v > 49'sh0_7FFF_FFFF_FFFF) begin
      res = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -49'sh0_8000_0000_0000) begin
      res = -48'sh7FFF_FFFF_FFFF - 48'sd1;
    end else begin
      res = v[47:0];
    end
    return res;
  endfunction

  function automatic logic ovf48(input logic signed [48:0] v);
    return (v > 49'sh0_7FFF_FFFF_FFFF) || (v < -49'sh0_8000_0000_0000);
  endfunction

  function automatic logic [25:0] mag27(input logic signed [26:0] v);
    logic [26:0] m;
    m = v[26] ? 27'(-v) : 27'(v);
    return m[25:0];
  endfunction

  assign dxm = mag27(item_r.dx);
  assign dym = mag27(item_r.dy);
  assign dzm = mag27(item_r.dz);

  // Operand select for the current multiply step
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sh  = 7'd32;
    op_lim = U63;
    op_neg = 1'b0;
    unique case (op_r)
      OP_SQX: begin op_a = 64'(dxm); op_b = 64'(dxm); op_sh = 7'd0; end
      OP_SQY: begin op_a = 64'(dym); op_b = 64'(dym); op_sh = 7'd0; end
      OP_SQZ: begin op_a = 64'(dzm); op_b = 64'(dzm); op_sh = 7'd0; end
      OP_S2:  begin op_a = s_r;  op_b = s_r; end
      OP_S4:  begin op_a = s2_r; op_b = s2_r; end
      OP_S3:  begin op_a = s2_r; op_b = s_r; end
      OP_C:   begin op_a = a_r; op_b = b_mag_r; op_neg = b_neg_r; end
      OP_DF:  begin op_a = c_mag_r; op_b = 64'(time_step); op_neg = c_neg_r; end
      OP_TX: begin
        op_a = df_mag_r; op_b = 64'(dxm); op_sh = 7'd20; op_lim = S48LIM;
        op_neg = df_neg_r ^ item_r.dx[26];
      end
      OP_TY: begin
        op_a = df_mag_r; op_b = 64'(dym); op_sh = 7'd20; op_lim = S48LIM;
        op_neg = df_neg_r ^ item_r.dy[26];
      end
      OP_TZ: begin
        op_a = df_mag_r; op_b = 64'(dzm); op_sh = 7'd20; op_lim = S48LIM;
        op_neg = df_neg_r ^ item_r.dz[26];
      end
      default: begin op_a = '0; end
    endcase
  end

  // Shared multiplier and finishing shift with saturation
  assign a_part  = cnt_r[1] ? op_a[63:32] : op_a[31:0];
  assign b_part  = cnt_r[0] ? op_b[63:32] : op_b[31:0];
  assign prod    = a_part * b_part;
  assign qwide   = acc_r >> op_sh;
  assign mul_sat = qwide > {64'd0, op_lim};
  assign mul_res = mul_sat ? op_lim : qwide[63:0];
  assign term    = op_neg ? -49'(mul_res[47:0]) : 49'(mul_res[47:0]);

  // Reciprocal step, one quotient bit per cycle
  assign rem_sh = {rem_r, (cnt_r == 7'd0)};
  assign div_ge = rem_sh >= {1'b0, r_r};

  // Force factor prep
  assign a_sat = s4_r > A_LIM;
  assign t_sat = s3_r > T_LIM;
  assign t_val = t_sat ? U63 : {s3_r[62:0], 1'b0};

  // Result sums
  assign mx = 49'(item_r.mom_x) + 49'(sum_x_r);
  assign my = 49'(item_r.mom_y) + 49'(sum_y_r);
  assign mz = 49'(item_r.mom_z) + 49'(sum_z_r);
  assign ox_sat = ovf48(mx);
  assign oy_sat = ovf48(my);
  assign oz_sat = ovf48(mz);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = head.proc ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          priority case (op_r)
            OP_SQZ:  state_nxt = ST_CHK;
            OP_S3:   state_nxt = ST_PREP;
            OP_TZ:   state_nxt = ST_EMIT;
            default: state_nxt = ST_MUL;
          endcase
        end
      end
      ST_CHK: begin
        priority if (r_r > {cutoff_sq, 20'd0}) begin
          state_nxt = ST_EMIT;
        end else if (r_r <= 52'd512) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  state_nxt = (cnt_r == DIV_LAST) ? ST_MUL : ST_DIV;
      ST_PREP: state_nxt = ST_MUL;
      ST_EMIT: begin
        if (!item_r.emit || out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer
  always_comb begin
    pop      = (state_r == ST_IDLE) && !qstat.empty;
    out_load = (state_r == ST_EMIT) && item_r.emit && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      clip_r  <= 1'b0;
      cnt_r   <= '0;
      op_r    <= OP_SQX;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            item_r <= head;
            op_r   <= OP_SQX;
            cnt_r  <= '0;
            r_r    <= '0;
          end
        end
        ST_MUL: begin
          // partial products, then accumulate, then finish
          if (cnt_r <= 7'd3) begin
            pp_r   <= prod;
            pp_w_r <= 2'(cnt_r[1] + cnt_r[0]);
          end
          if (cnt_r == 7'd0) begin
            acc_r <= '0;
          end else if (cnt_r <= 7'd4) begin
            acc_r <= acc_r + (128'(pp_r) << (7'd32 * 7'(pp_w_r)));
          end
          if (cnt_r == MUL_LAST) begin
            cnt_r <= '0;
            if (op_r == OP_S2 || op_r == OP_S4 || op_r == OP_S3 ||
                op_r == OP_C || op_r == OP_DF) begin
              clip_r <= clip_r | mul_sat;
            end
            unique case (op_r)
              OP_SQX, OP_SQY, OP_SQZ: r_r <= r_r + acc_r[51:0];
              OP_S2: s2_r <= mul_res;
              OP_S4: s4_r <= mul_res;
              OP_S3: s3_r <= mul_res;
              OP_C: begin
                c_mag_r <= mul_res;
                c_neg_r <= op_neg;
              end
              OP_DF: begin
                df_mag_r <= mul_res;
                df_neg_r <= op_neg;
              end
              OP_TX: begin
                sum_x_r <= sat48(49'(sum_x_r) + term);
                clip_r  <= clip_r | mul_sat | ovf48(49'(sum_x_r) + term);
              end
              OP_TY: begin
                sum_y_r <= sat48(49'(sum_y_r) + term);
                clip_r  <= clip_r | mul_sat | ovf48(49'(sum_y_r) + term);
              end
              OP_TZ: begin
                sum_z_r <= sat48(49'(sum_z_r) + term);
                clip_r  <= clip_r | mul_sat | ovf48(49'(sum_z_r) + term);
              end
              default: ;
            endcase
            if (op_r != OP_SQZ && op_r != OP_S3 && op_r != OP_TZ) begin
              op_r <= ljfa_op_t'(4'(op_r + 4'd1));
            end
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_CHK: begin
          op_r  <= OP_S2;
          cnt_r <= '0;
          rem_r <= '0;
          q_r   <= '0;
          if (r_r <= {cutoff_sq, 20'd0} && r_r <= 52'd512) begin
            s_r    <= U63;
            clip_r <= 1'b1;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? 52'(rem_sh - {1'b0, r_r}) : rem_sh[51:0];
          q_r   <= {q_r[62:0], div_ge};
          if (cnt_r == DIV_LAST) begin
            s_r   <= {q_r[62:0], div_ge};
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_PREP: begin
          a_r     <= a_sat ? U63 : 64'(s4_r * 64'd24);
          b_neg_r <= t_val > ONE32;
          b_mag_r <= (t_val > ONE32) ? t_val - ONE32 : ONE32 - t_val;
          clip_r  <= clip_r | a_sat | t_sat;
          op_r    <= OP_C;
          cnt_r   <= '0;
        end
        ST_EMIT: begin
          if (out_load) begin
            sum_x_r <= '0;
            sum_y_r <= '0;
            sum_z_r <= '0;
            clip_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= sat48(mx);
      out_y_r   <= sat48(my);
      out_z_r   <= sat48(mz);
      out_sat_r <= clip_r | ox_sat | oy_sat | oz_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mom_out_x = out_x_r;
  assign out_mom_out_y = out_y_r;
  assign out_mom_out_z = out_z_r;
  assign out_saturated = out_sat_r;
endmodule
`default_nettype wire

// ===== hdl/lennard_jones_force_accumulator_core.sv =====
// From input accept to result register: a lone particle goes straight to emit; a pair
// in the coarse box but outside cutoff takes the three squaring steps; a pair at contact
// skips the bit-serial reciprocal; a pair inside cutoff takes the reciprocal plus eleven
// steps on the shared 32x32 multiplier. The back-end sequencer works on one item at a
// time; the 4-entry queue takes items while the back end works. Synchronous reset clears
// control, sums and clip flag and loads register defaults; no clearing pass.
`default_nettype none
module lennard_jones_force_accumulator_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] in_key_x,
  input  wire  signed [31:0] in_key_y,
  input  wire  signed [31:0] in_key_z,
  input  wire  signed [31:0] in_nbr_x,
  input  wire  signed [31:0] in_nbr_y,
  input  wire  signed [31:0] in_nbr_z,
  input  wire  signed [47:0] in_mom_in_x,
  input  wire  signed [47:0] in_mom_in_y,
  input  wire  signed [47:0] in_mom_in_z,
  input  wire                in_has_partner,
  input  wire                in_last_partner,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [47:0] out_mom_out_x,
  output logic signed [47:0] out_mom_out_y,
  output logic signed [47:0] out_mom_out_z,
  output logic               out_saturated
);
  import ljfa_pkg::*;

  logic [27:0] cutoff_sq_r;
  logic [31:0] time_step_r;
  ljfa_qstat_t qstat;
  ljfa_item_t  push_item, head;
  logic        push, pop;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_sq_r <= CUTOFF_SQ_RST;
      time_step_r <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CUTOFF_SQ: cutoff_sq_r <= cfg_data[27:0];
        CFG_TIME_STEP: time_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ljfa_front u_front (
    .in_valid, .in_ready,
    .in_key_x, .in_key_y, .in_key_z,
    .in_nbr_x, .in_nbr_y, .in_nbr_z,
    .in_mom_in_x, .in_mom_in_y, .in_mom_in_z,
    .in_has_partner, .in_last_partner,
    .qstat, .push, .push_item
  );

  ljfa_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .head, .qstat
  );

  ljfa_back u_back (
    .clk, .rst_n,
    .cutoff_sq(cutoff_sq_r), .time_step(time_step_r),
    .head, .qstat, .pop,
    .out_valid, .out_ready,
    .out_mom_out_x, .out_mom_out_y, .out_mom_out_z, .out_saturated
  );
endmodule
`default_nettype wire

// ===== hdl/ljfa_checker.sv =====
// Port-level checks for the force accumulator core, and the bind that
// attaches them. Depends only on the top level's ports.
`default_nettype none
module ljfa_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [47:0] out_mom_out_x,
  input wire               out_saturated
);
  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the queue, so input is taken
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // A stalled result holds its value and flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mom_out_x) &&
    $stable(out_saturated))
    else $error("stalled result changed");
endmodule

bind lennard_jones_force_accumulator_core ljfa_checker u_ljfa_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_mom_out_x, .out_saturated
);
`default_nettype wire
